// File: hw/rtl/sirt_pkg.sv
// Shared types, constants and the symbol lookup for the radix text converter.
`default_nettype none
package sirt_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int NUM_DIGITS  = 32;
    localparam int VALUE_W     = 32;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [4:0] MIN_COUNT = 5'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SYM_LOW  = 2'd0;
    localparam logic [1:0] REG_SYM_HIGH = 2'd1;
    localparam logic [1:0] REG_COUNT    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_EMIT
    } t_state;

    // Control of the digit accumulator
    typedef struct packed {
        logic clear;
        logic shift;
        logic data;
    } t_dig_ctl;

    function automatic logic [7:0] sym_at(input logic [127:0] syms, input logic [3:0] idx);
        sym_at = syms[{idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sirt_check.sv
// Alphabet checker: walks the symbols one per cycle and flags bad or duplicate ones.
`default_nettype none
module sirt_check
    import sirt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_syms,
    input  wire logic [4:0]   i_count,
    output logic              o_ok
);

    logic       r_run;
    logic [3:0] r_idx;
    logic       r_ok;
    logic       n_bad;
    logic [7:0] w_sym;

    assign w_sym = sym_at(i_syms, r_idx);

    always_comb begin
        n_bad = 1'b0;
        if ({1'b0, r_idx} < i_count) begin
            if (w_sym == CHAR_NUL || w_sym == CHAR_PLUS || w_sym == CHAR_MINUS) begin
                n_bad = 1'b1;
            end
            // compare against every later symbol in use
            for (int j = 0; j < MAX_SYMBOLS; j++) begin
                if (4'(j) > r_idx && 5'(j) < i_count && sym_at(i_syms, 4'(j)) == w_sym) begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_idx <= '0;
            r_ok  <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_idx <= '0;
            r_ok  <= (i_count >= MIN_COUNT) && (i_count <= 5'(MAX_SYMBOLS));
        end else if (r_run) begin
            if (n_bad) begin
                r_ok <= 1'b0;
            end
            r_idx <= r_idx + 4'd1;
            if (r_idx == 4'(MAX_SYMBOLS - 1)) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_ok = r_ok;

endmodule
`default_nettype wire

// File: hw/rtl/sirt_digits.sv
// Radix digit accumulator: shifts the magnitude in as radix digits, one bit a cycle while shift is set.
`default_nettype none
module sirt_digits
    import sirt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_dig_ctl   i_ctl,
    input  wire logic [4:0] i_radix,
    input  wire logic [4:0] i_rd_idx,
    output logic [3:0]      o_digit,
    output logic [5:0]      o_nd
);

    logic [NUM_DIGITS-1:0][3:0] r_dig;
    logic [NUM_DIGITS-1:0][3:0] n_dig;
    logic [5:0]                 r_nd;
    logic [NUM_DIGITS-1:0]      w_gen;
    logic [NUM_DIGITS-1:0]      w_gop;
    logic [NUM_DIGITS:0]        w_sum;
    logic [NUM_DIGITS:0]        w_cin;
    logic [4:0]                 w_twice;

    // A digit doubles to 2d+c; it generates a carry when 2d >= radix and
    // passes one on when only 2d+1 reaches it. One add resolves the chain.
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            w_gen[k] = {r_dig[k], 1'b0} >= i_radix;
            w_gop[k] = {r_dig[k], 1'b1} >= i_radix;
        end
        w_sum = {1'b0, w_gen} + {1'b0, w_gop} + {{NUM_DIGITS{1'b0}}, i_ctl.data};
        w_cin = w_sum ^ {1'b0, w_gen} ^ {1'b0, w_gop};
        w_twice = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            w_twice  = {r_dig[k], w_cin[k]};
            n_dig[k] = w_cin[k+1] ? 4'(w_twice - i_radix) : w_twice[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_dig <= '0;
            r_nd  <= 6'd1;
        end else if (i_ctl.shift) begin
            r_dig <= n_dig;
            // grow by one digit when a carry reaches the first unused place
            r_nd  <= r_nd + {5'd0, w_cin[r_nd]};
        end
    end

    assign o_digit = r_dig[i_rd_idx];
    assign o_nd    = r_nd;

endmodule
`default_nettype wire

// File: hw/rtl/signed_integer_to_radix_text_top.sv
// Top level of the signed integer to radix text converter.
//
// Usage: load the alphabet through the APB port (symbols 0..7 at address 0,
// symbols 8..15 at address 8, symbol count at address 16, 64-bit data),
// then pulse start with i_value while busy is low. The transaction is taken
// at that edge and busy rises for the whole conversion.
// The magnitude is shifted into a row of radix digit cells one bit a cycle
// while the alphabet checker walks the 16 symbols; the load state then
// loads the digit count. Characters then leave one per cycle on
// o_character with o_strobe high for one cycle each: '-' first for a
// negative value, then the digits most significant first, o_last_char on
// the final one. An invalid alphabet yields no characters and busy drops
// after the load state. The receiver cannot stall; every strobe is a
// transaction. Reset (synchronous, active low) clears the alphabet
// registers, the state and the output strobe and returns the block to idle.
`default_nettype none
module signed_integer_to_radix_text_top
    import sirt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_value,
    output logic [7:0]       o_character,
    output logic             o_last_char,
    output logic             o_strobe
);

    logic [63:0] r_sym_low;
    logic [63:0] r_sym_high;
    logic [4:0]  r_count;
    logic [127:0] w_syms;
    logic [1:0]  w_reg;
    logic        w_wr;

    t_state      r_state;
    t_state      n_state;
    logic [VALUE_W-1:0] r_mag;
    logic [4:0]  r_bit;
    logic        r_neg;
    logic        r_sign_pend;
    logic [4:0]  r_idx;
    logic [7:0]  r_char;
    logic        r_last;
    logic        r_strobe;

    logic        w_accept;
    logic        w_ok;
    logic [3:0]  w_digit;
    logic [5:0]  w_nd;
    t_dig_ctl    w_dig_ctl;

    assign w_syms   = {r_sym_high, r_sym_low};
    assign w_reg    = paddr[4:3];
    assign w_wr     = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_count    <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_SYM_LOW:  r_sym_low  <= pwdata;
                REG_SYM_HIGH: r_sym_high <= pwdata;
                REG_COUNT:    r_count    <= pwdata[4:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_SYM_LOW:  prdata = r_sym_low;
            REG_SYM_HIGH: prdata = r_sym_high;
            REG_COUNT:    prdata = {59'd0, r_count};
            default:      prdata = '0;
        endcase
    end

    sirt_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_syms  (w_syms),
        .i_count (r_count),
        .o_ok    (w_ok)
    );

    assign w_dig_ctl.clear = w_accept;
    assign w_dig_ctl.shift = (r_state == ST_CONV);
    assign w_dig_ctl.data  = r_mag[VALUE_W-1];

    sirt_digits u_digits (
        .i_clk    (i_clk),
        .i_ctl    (w_dig_ctl),
        .i_radix  (r_count),
        .i_rd_idx (r_idx),
        .o_digit  (w_digit),
        .o_nd     (w_nd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CONV;
            ST_CONV: if (r_bit == 5'(VALUE_W - 1)) n_state = ST_LOAD;
            ST_LOAD: n_state = w_ok ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (!r_sign_pend && r_idx == 5'd0) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_neg <= i_value[VALUE_W-1];
                    r_mag <= i_value[VALUE_W-1] ? (32'd0 - i_value) : i_value;
                    r_bit <= '0;
                end
            end
            ST_CONV: begin
                r_mag <= {r_mag[VALUE_W-2:0], 1'b0};
                r_bit <= r_bit + 5'd1;
            end
            ST_LOAD: begin
                r_sign_pend <= r_neg;
                r_idx       <= 5'(w_nd - 6'd1);
            end
            ST_EMIT: begin
                if (r_sign_pend) begin
                    r_char      <= CHAR_MINUS;
                    r_last      <= 1'b0;
                    r_sign_pend <= 1'b0;
                end else begin
                    r_char <= sym_at(w_syms, w_digit);
                    r_last <= (r_idx == 5'd0);
                    // advance toward the least significant digit
                    if (r_idx != 5'd0) begin
                        r_idx <= r_idx - 5'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_character = r_char;
    assign o_last_char = r_last;
    assign o_strobe    = r_strobe;

endmodule
`default_nettype wire

// File: bench/signed_integer_to_radix_text_top_test.sv
// Self-checking testbench for the signed integer to radix text converter.
`default_nettype none
module signed_integer_to_radix_text_top_test
    import sirt_pkg::*;
();

    localparam int          HALF_PERIOD   = 10;
    localparam int          DRAIN_CYCLES  = 68;
    localparam int          IDLE_LIMIT    = 400;
    localparam int          RANDOM_PHASES = 16;
    localparam int          PHASE_ITEMS   = 20;
    localparam logic [4:0]  ADDR_SYM_LOW  = {REG_SYM_LOW, 3'b000};
    localparam logic [4:0]  ADDR_SYM_HIGH = {REG_SYM_HIGH, 3'b000};
    localparam logic [4:0]  ADDR_COUNT    = {REG_COUNT, 3'b000};
    localparam logic [4:0]  ADDR_UNUSED   = 5'd24;
    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_text_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [31:0] i_value;
    logic [7:0]  o_character;
    logic        o_last_char;
    logic        o_strobe;

    // Alphabet as currently held by the block
    logic [63:0] alpha_low;
    logic [63:0] alpha_high;
    logic [4:0]  alpha_count;

    t_text_char  pending_chars[$];
    int          mismatch_count;

    signed_integer_to_radix_text_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_character (o_character),
        .o_last_char (o_last_char),
        .o_strobe    (o_strobe)
    );

    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    function automatic logic [7:0] alphabet_symbol(input int idx);
        logic [127:0] all_syms;
        all_syms = {alpha_high, alpha_low};
        return all_syms[8*idx +: 8];
    endfunction

    function automatic bit alphabet_valid();
        logic [7:0] c;
        if (alpha_count < MIN_COUNT || alpha_count > MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < alpha_count; i++) begin
            c = alphabet_symbol(i);
            if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < alpha_count; j++)
                if (alphabet_symbol(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the text of one value and queue its characters
    task automatic predict_text(input logic [31:0] value);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [4:0]  digits[32];
        int          nd;
        if (!alphabet_valid())
            return;
        radix = {27'd0, alpha_count};
        mag   = value[31] ? (32'd0 - value) : value;
        nd    = 0;
        do begin
            digits[nd] = 5'(mag % radix);
            nd++;
            mag = mag / radix;
        end while (mag != 0 && nd < 32);
        if (value[31])
            pending_chars.push_back('{character: CHAR_MINUS, last_char: 1'b0});
        while (nd > 0) begin
            nd--;
            pending_chars.push_back('{character: alphabet_symbol(digits[nd]),
                                      last_char: (nd == 0)});
        end
    endtask

    always @(posedge i_clk) begin : check_chars
        t_text_char exp_char;
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_character, o_last_char);
                mismatch_count++;
            end else begin
                exp_char = pending_chars.pop_front();
                if (o_character !== exp_char.character) begin
                    $display("%0t: character mismatch: expected %h, actual %h",
                             $time, exp_char.character, o_character);
                    mismatch_count++;
                end
                if (o_last_char !== exp_char.last_char) begin
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, exp_char.last_char, o_last_char);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (addr)
            ADDR_SYM_LOW:  alpha_low   = data;
            ADDR_SYM_HIGH: alpha_high  = data;
            ADDR_COUNT:    alpha_count = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_alphabet(input logic [127:0] syms, input logic [63:0] count_word);
        reg_write(ADDR_SYM_LOW, syms[63:0]);
        reg_write(ADDR_SYM_HIGH, syms[127:64]);
        reg_write(ADDR_COUNT, count_word);
    endtask

    function automatic logic [127:0] alphabet_from_text(input string s);
        logic [127:0] syms;
        syms = '0;
        for (int i = 0; i < s.len() && i < MAX_SYMBOLS; i++)
            syms[8*i +: 8] = s[i];
        return syms;
    endfunction

    // Hold start until the block takes the transaction, then drop it
    task automatic send_value(input logic [31:0] value, input int gap);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        predict_text(value);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Wait for every queued character and for the block to fall idle
    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((pending_chars.size() != 0 || busy) && waited < IDLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived, next expected %h",
                     $time, pending_chars.size(), pending_chars[0].character);
            mismatch_count++;
            pending_chars.delete();
        end
    endtask

    function automatic logic [127:0] random_alphabet();
        logic [127:0] syms;
        logic [7:0]   c;
        bit           clash;
        syms = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            do begin
                c     = 8'($urandom_range(1, 255));
                clash = (c == CHAR_PLUS || c == CHAR_MINUS);
                for (int j = 0; j < i; j++)
                    if (syms[8*j +: 8] == c)
                        clash = 1'b1;
            end while (clash);
            syms[8*i +: 8] = c;
        end
        return syms;
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'($urandom_range(0, 40));
            1: v = 32'd0 - 32'($urandom_range(1, 40));
            2: begin
                case ($urandom_range(0, 3))
                    0: v = MOST_NEGATIVE;
                    1: v = MOST_POSITIVE;
                    2: v = 32'd0;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            3: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_reset_alphabet();
        // the alphabet registers are all zero after reset, so nothing comes out
        send_value(32'd7, 0);
        wait_idle();
    endtask

    task automatic test_decimal_extremes();
        load_alphabet(alphabet_from_text("0123456789"), 64'd10);
        send_value(32'd0, 0);
        send_value(32'd1, 3);
        send_value(32'hFFFF_FFFF, 0);
        send_value(MOST_POSITIVE, 7);
        send_value(MOST_NEGATIVE, 1);
        send_value(32'd10, 0);
        send_value(32'hFFFF_FFF6, 5);
        send_value(32'd123456789, 2);
        wait_idle();
    endtask

    task automatic test_binary_longest();
        load_alphabet(alphabet_from_text("01"), 64'd2);
        send_value(MOST_NEGATIVE, 0);
        send_value(MOST_POSITIVE, 0);
        send_value(32'd5, 4);
        wait_idle();
    endtask

    task automatic test_full_alphabet();
        logic [127:0] syms;
        syms = alphabet_from_text("0123456789ABCDEF");
        syms[127:120] = 8'hFF;
        load_alphabet(syms, 64'd16);
        send_value(32'hDEAD_BEEF, 0);
        send_value(MOST_POSITIVE, 2);
        send_value(32'hFFFF_FFF0, 0);
        wait_idle();
    endtask

    task automatic test_invalid_alphabets();
        logic [127:0] syms;
        syms = alphabet_from_text("0123456789ABCDEF");
        load_alphabet(syms, 64'd1);
        send_value(32'd42, 0);
        wait_idle();
        reg_write(ADDR_COUNT, 64'd17);
        send_value(32'd42, 0);
        wait_idle();
        reg_write(ADDR_COUNT, 64'd31);
        send_value(32'd42, 0);
        wait_idle();
        load_alphabet(alphabet_from_text("01+3"), 64'd4);
        send_value(32'd42, 0);
        wait_idle();
        load_alphabet(alphabet_from_text("0-23"), 64'd4);
        send_value(32'd42, 0);
        wait_idle();
        syms = alphabet_from_text("012345");
        syms[15:8] = CHAR_NUL;
        load_alphabet(syms, 64'd6);
        send_value(32'd42, 0);
        wait_idle();
        load_alphabet(alphabet_from_text("abcdea"), 64'd6);
        send_value(32'd42, 0);
        wait_idle();
    endtask

    task automatic test_unused_symbols();
        // bad bytes beyond the count must not spoil the alphabet
        load_alphabet(alphabet_from_text("xyz-+x"), 64'd3);
        // a write above the last register leaves everything alone
        reg_write(ADDR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(32'hFFFF_FF00, 0);
        wait_idle();
    endtask

    task automatic test_random_alphabets();
        logic [127:0] syms;
        logic [4:0]   count;
        logic [7:0]   bad_byte;
        int           a;
        int           b;
        bit           steady;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            syms  = random_alphabet();
            count = 5'($urandom_range(MIN_COUNT, MAX_SYMBOLS));
            case ($urandom_range(0, 7))
                0: count = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 1))
                                                       : 5'($urandom_range(17, 31));
                1: begin
                    case ($urandom_range(0, 2))
                        0: bad_byte = CHAR_NUL;
                        1: bad_byte = CHAR_PLUS;
                        default: bad_byte = CHAR_MINUS;
                    endcase
                    syms[8*$urandom_range(0, count - 1) +: 8] = bad_byte;
                end
                2: begin
                    a = $urandom_range(0, count - 1);
                    do b = $urandom_range(0, count - 1); while (b == a);
                    syms[8*b +: 8] = syms[8*a +: 8];
                end
                default: ;
            endcase
            if (phase == 0)
                count = 5'd16;
            load_alphabet(syms, {$urandom, 27'($urandom), count});
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off now and then until the text so far has drained
                if (n == PHASE_ITEMS / 2 && phase % 3 == 0)
                    while (pending_chars.size() != 0) @(posedge i_clk);
                send_value(random_value(), steady ? 0 : $urandom_range(0, 7));
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        start          = 1'b0;
        i_value        = '0;
        alpha_low      = '0;
        alpha_high     = '0;
        alpha_count    = '0;
        mismatch_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_alphabet();
        test_decimal_extremes();
        test_binary_longest();
        test_full_alphabet();
        test_invalid_alphabets();
        test_unused_symbols();
        test_random_alphabets();
        wait_idle();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
